/* rtl/core/x86enc_pkg.sv */
// ============================================================================
// x86enc_pkg
// Shared types, operation codes and the byte-building function for the
// x86-64 instruction encoder.
// ============================================================================
package x86enc_pkg;

    // Operation selector codes
    typedef enum logic [4:0] {
        FN_RET     = 5'd0,
        FN_LEAVE   = 5'd1,
        FN_PUSH    = 5'd2,
        FN_POP     = 5'd3,
        FN_CALLR   = 5'd4,
        FN_MOVRQ   = 5'd5,
        FN_MOVRR   = 5'd6,
        FN_MOVRAR  = 5'd7,
        FN_MOVRABR = 5'd8,
        FN_MOVRRA  = 5'd9,
        FN_MOVRRAB = 5'd10,
        FN_INC     = 5'd11,
        FN_ADDRB   = 5'd12,
        FN_ADDRR   = 5'd13,
        FN_DEC     = 5'd14,
        FN_SUBRB   = 5'd15,
        FN_SUBRR   = 5'd16,
        FN_XOR     = 5'd17,
        FN_CMP     = 5'd18,
        FN_TEST    = 5'd19,
        FN_JNE     = 5'd20
    } func_t;

    // Result status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_REG = 1'b1;

    // Longest instruction: REX, opcode and a quadword immediate
    localparam int MAX_BYTES  = 10;
    localparam int IDX_W      = $clog2(MAX_BYTES);

    // Instruction queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Encoding constants
    localparam logic [7:0] REX_W      = 8'h48;
    localparam logic [3:0] SP_REG     = 4'd4;
    localparam logic [7:0] SIB_SP     = 8'h24;
    localparam logic [7:0] MOD_REG    = 8'hC0;
    localparam logic [7:0] MOD_IND    = 8'h00;
    localparam logic [7:0] MOD_DISP8  = 8'h40;

    // One encoded instruction as held in the queue
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
        logic                      status;
    } desc_t;

    // Operation codes that produce output
    function automatic logic func_known(input logic [4:0] func);
        return func <= FN_JNE;
    endfunction

    function automatic logic [7:0] modrm(input logic [7:0] mode,
                                         input logic [2:0] rm,
                                         input logic [2:0] rg);
        return mode | {2'b00, rg, rm};
    endfunction

    // Build the full byte list of one instruction
    function automatic desc_t encode(input logic [4:0]  func,
                                     input logic [4:0]  d,
                                     input logic [4:0]  s,
                                     input logic [7:0]  dsp,
                                     input logic [7:0]  imm,
                                     input logic [63:0] q);
        desc_t      r;
        logic       one;
        logic       two;
        logic [7:0] rex1;
        logic [7:0] rex2;
        logic [7:0] rexr;
        r      = '0;
        one    = 1'b0;
        two    = 1'b0;
        rex1   = REX_W | {7'd0, d[3]};
        rex2   = REX_W | {5'd0, s[3], 1'b0, d[3]};
        rexr   = REX_W | {5'd0, d[3], 2'b00};
        r.status = ST_OK;

        // Which register operands the operation checks
        unique case (func)
            FN_RET, FN_LEAVE, FN_JNE: ;
            FN_PUSH, FN_POP, FN_CALLR, FN_MOVRQ,
            FN_INC, FN_ADDRB, FN_DEC, FN_SUBRB: one = 1'b1;
            default: two = 1'b1;
        endcase

        if ((one && d[4]) || (two && (d[4] || s[4]))) begin
            r.status = ST_BAD_REG;
            return r;
        end

        unique case (func)
            FN_RET: r.bytes[0] = 8'hC3;
            FN_LEAVE: r.bytes[0] = 8'hC9;
            FN_PUSH:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'h50 | {5'd0, d[2:0]};
                r.last_idx = IDX_W'(1);
            end
            FN_POP:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'h58 | {5'd0, d[2:0]};
                r.last_idx = IDX_W'(1);
            end
            FN_CALLR:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'hFF;
                r.bytes[2] = 8'hD0 | {5'd0, d[2:0]};
                r.last_idx = IDX_W'(2);
            end
            FN_MOVRQ:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'hB8 | {5'd0, d[2:0]};
                for (int k = 0; k < 8; k++) begin
                    r.bytes[2 + k] = q[8*k +: 8];
                end
                r.last_idx = IDX_W'(MAX_BYTES - 1);
            end
            FN_MOVRR:
            begin
                r.bytes[0] = rex2;
                r.bytes[1] = 8'h89;
                r.bytes[2] = modrm(MOD_REG, d[2:0], s[2:0]);
                r.last_idx = IDX_W'(2);
            end
            FN_MOVRAR:
            begin
                r.bytes[0] = rex2;
                r.bytes[1] = 8'h89;
                if (d[3:0] == SP_REG) begin
                    r.bytes[2] = modrm(MOD_IND, 3'd4, s[2:0]);
                    r.bytes[3] = SIB_SP;
                    r.last_idx = IDX_W'(3);
                end else begin
                    r.bytes[2] = modrm(MOD_IND, d[2:0], s[2:0]);
                    r.last_idx = IDX_W'(2);
                end
            end
            FN_MOVRABR:
            begin
                r.bytes[0] = rex2;
                r.bytes[1] = 8'h89;
                if (d[3:0] == SP_REG) begin
                    r.bytes[2] = modrm(MOD_DISP8, 3'd4, s[2:0]);
                    r.bytes[3] = SIB_SP;
                    r.bytes[4] = dsp;
                    r.last_idx = IDX_W'(4);
                end else begin
                    r.bytes[2] = modrm(MOD_DISP8, d[2:0], s[2:0]);
                    r.bytes[3] = dsp;
                    r.last_idx = IDX_W'(3);
                end
            end
            FN_MOVRRA:
            begin
                r.bytes[1] = 8'h8B;
                if (s[3:0] == SP_REG) begin
                    r.bytes[0] = rexr;
                    r.bytes[2] = modrm(MOD_IND, 3'd4, d[2:0]);
                    r.bytes[3] = SIB_SP;
                    r.last_idx = IDX_W'(3);
                end else begin
                    r.bytes[0] = rex2;
                    r.bytes[2] = modrm(MOD_IND, d[2:0], s[2:0]);
                    r.last_idx = IDX_W'(2);
                end
            end
            FN_MOVRRAB:
            begin
                r.bytes[1] = 8'h8B;
                if (s[3:0] == SP_REG) begin
                    r.bytes[0] = rexr;
                    r.bytes[2] = modrm(MOD_DISP8, 3'd4, d[2:0]);
                    r.bytes[3] = SIB_SP;
                    r.bytes[4] = dsp;
                    r.last_idx = IDX_W'(4);
                end else begin
                    r.bytes[0] = rex2;
                    r.bytes[2] = modrm(MOD_DISP8, d[2:0], s[2:0]);
                    r.bytes[3] = dsp;
                    r.last_idx = IDX_W'(3);
                end
            end
            FN_INC:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'hFF;
                r.bytes[2] = 8'hC0 | {5'd0, d[2:0]};
                r.last_idx = IDX_W'(2);
            end
            FN_ADDRB:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'h83;
                r.bytes[2] = 8'hC0 | {5'd0, d[2:0]};
                r.bytes[3] = imm;
                r.last_idx = IDX_W'(3);
            end
            FN_DEC:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'hFF;
                r.bytes[2] = 8'hC8 | {5'd0, d[2:0]};
                r.last_idx = IDX_W'(2);
            end
            FN_SUBRB:
            begin
                r.bytes[0] = rex1;
                r.bytes[1] = 8'h83;
                r.bytes[2] = 8'hE8 | {5'd0, d[2:0]};
                r.bytes[3] = imm;
                r.last_idx = IDX_W'(3);
            end
            FN_ADDRR, FN_SUBRR, FN_XOR, FN_CMP, FN_TEST:
            begin
                r.bytes[0] = rex2;
                unique case (func)
                    FN_ADDRR: r.bytes[1] = 8'h01;
                    FN_SUBRR: r.bytes[1] = 8'h29;
                    FN_XOR:   r.bytes[1] = 8'h31;
                    FN_CMP:   r.bytes[1] = 8'h39;
                    default:  r.bytes[1] = 8'h85;
                endcase
                r.bytes[2] = modrm(MOD_REG, d[2:0], s[2:0]);
                r.last_idx = IDX_W'(2);
            end
            default:
            begin
                // Short jne and undefined codes (the latter never queued)
                r.bytes[0] = 8'h75;
                r.bytes[1] = imm;
                r.last_idx = IDX_W'(1);
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/x86enc_req_if.sv */
// ============================================================================
// x86enc_req_if
// Request channel: one instruction request per transfer.
// ============================================================================
interface x86enc_req_if;
    logic              valid;
    logic              ready;
    logic [4:0]        func;
    logic [4:0]        dst_reg;
    logic [4:0]        src_reg;
    logic [7:0]        disp8;
    logic signed [7:0] imm8;
    logic [63:0]       imm64;

    modport source (
        output valid, func, dst_reg, src_reg, disp8, imm8, imm64,
        input  ready
    );
    modport sink (
        input  valid, func, dst_reg, src_reg, disp8, imm8, imm64,
        output ready
    );
endinterface

/* rtl/core/x86enc_code_if.sv */
// ============================================================================
// x86enc_code_if
// Code channel: one machine code byte per transfer.
// ============================================================================
interface x86enc_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    logic       status;

    modport source (
        output valid, code_byte, last_byte, status,
        input  ready
    );
    modport sink (
        input  valid, code_byte, last_byte, status,
        output ready
    );
endinterface

/* rtl/core/x86enc_fifo.sv */
// ============================================================================
// x86enc_fifo
// Short queue of encoded instructions between the front and the back.
// ============================================================================
module x86enc_fifo
    import x86enc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head
);

    desc_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/x86enc_front.sv */
// ============================================================================
// x86enc_front
// Takes instruction requests, checks operands and builds the byte list.
// ============================================================================
module x86enc_front
    import x86enc_pkg::*;
(
    x86enc_req_if.sink req,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_data
);

    // Accept whenever the queue has room; undefined operations are dropped
    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full && func_known(req.func);
    assign q_data    = encode(req.func, req.dst_reg, req.src_reg,
                              req.disp8, req.imm8, req.imm64);

endmodule

/* rtl/core/x86enc_back.sv */
// ============================================================================
// x86enc_back
// Serializes queued instructions into one code byte per transfer.
// ============================================================================
module x86enc_back
    import x86enc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  desc_t        q_head,
    output logic         q_pop,
    x86enc_code_if.source code
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       code_byte_reg;
    logic             last_byte_reg;
    logic             status_reg;
    logic             load;
    logic             at_last;

    // Output register is free when empty or being taken this cycle
    assign load    = q_valid && (!out_valid_reg || code.ready);
    assign at_last = (idx_reg == q_head.last_idx);
    assign q_pop   = load && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
            idx_next       = at_last ? '0 : idx_reg + 1'b1;
        end else if (code.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            code_byte_reg <= q_head.bytes[idx_reg];
            last_byte_reg <= at_last;
            status_reg    <= q_head.status;
        end
    end

    assign code.valid     = out_valid_reg;
    assign code.code_byte = code_byte_reg;
    assign code.last_byte = last_byte_reg;
    assign code.status    = status_reg;

endmodule

/* rtl/core/x86_64_instruction_encoder_top.sv */
// ============================================================================
// x86_64_instruction_encoder_top
// x86-64 instruction encoder: one request in, its machine code bytes out.
// ============================================================================
// Usage:
//   req  - instruction request channel (valid/ready). A transfer carries the
//          operation, register numbers, displacement and immediates.
//   code - code byte channel (valid/ready), one byte per transfer, with
//          last_byte on the final byte and status set for a bad register
//          (then a single zero byte).
// The front encodes a request in the cycle of its transfer and writes it
// into a two-entry instruction queue; the back reads the queue head and
// moves one byte per cycle into the output register whenever that register
// is empty or its byte is being taken. The first byte of a request passes
// through the queue entry and then the output register. An instruction of N
// bytes (1 to 10) is sent as N transfers; the output register sets the
// sustained rate. Requests keep being taken while the queue has room, also
// while a byte waits at a stalled receiver. Undefined operation codes are
// taken and produce no bytes.
// Reset empties the queue and clears the output valid; when the receiver
// stalls, the output byte holds and the queue fills, then req.ready drops.
// ============================================================================
module x86_64_instruction_encoder_top
    import x86enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    x86enc_req_if.sink    req,
    x86enc_code_if.source code
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    desc_t q_data;
    desc_t q_head;

    x86enc_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    x86enc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    x86enc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .code    (code)
    );

endmodule
